// ===== src/assert_macros.svh =====
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stream_substring_replace: assertion failed");
`define SSR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("stream_substring_replace: assertion failed");
`else
`define SSR_ASSERT(label, clk, rst_n, prop)
`define SSR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/ssr_pkg.sv =====
package ssr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int CHAR_W          = 8;
  localparam int WORD_BYTES      = 8;
  localparam int WORD_W          = CHAR_W * WORD_BYTES;
  localparam int LEN_W           = 4;
  localparam int CNT_W           = 3;
  localparam int POS_W           = 4;
  localparam int CFG_IDX_W       = 4;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = CFG_IDX_W'(3);

  // What sits between the fallback bytes and the flushed prefix
  typedef enum logic [1:0] {
    SEG_NONE,
    SEG_CHAR,
    SEG_REPL
  } mid_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] pattern;
    logic [WORD_W-1:0] repl;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
  } ssr_cfg_t;

  // Result sequence of one input item: pattern[0..b1), middle [b1..b2), pattern[0..total-b2)
  typedef struct packed {
    logic [POS_W-1:0]  b1;
    logic [POS_W-1:0]  b2;
    logic [POS_W-1:0]  total;
    mid_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              empty;
  } plan_t;

  function automatic logic [CHAR_W-1:0] byte_of(logic [WORD_W-1:0] w, logic [CNT_W-1:0] i);
    return w[CHAR_W*i +: CHAR_W];
  endfunction

  // Clamp to the limit, then stop at the first zero byte
  function automatic logic [LEN_W-1:0] eff_len(logic [WORD_W-1:0] w, logic [LEN_W-1:0] len,
                                               int limit);
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] r;
    logic             hit;
    n   = (len > LEN_W'(limit)) ? LEN_W'(limit) : len;
    r   = n;
    hit = 1'b0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (!hit && (LEN_W'(i) < n) && (w[CHAR_W*i +: CHAR_W] == '0)) begin
        r   = LEN_W'(i);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/ssr_in_if.sv =====
interface ssr_in_if;
  logic                        valid;
  logic                        ready;
  logic [ssr_pkg::CHAR_W-1:0]  in_char;
  logic                        in_end;

  modport source (output valid, output in_char, output in_end, input ready);
  modport sink   (input valid, input in_char, input in_end, output ready);
endinterface

// ===== src/ssr_out_if.sv =====
interface ssr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ssr_pkg::CHAR_W-1:0]  out_char;
  logic                        out_valid;
  logic                        out_end;

  modport source (output valid, output out_char, output out_valid, output out_end,
                  input ready);
  modport sink   (input valid, input out_char, input out_valid, input out_end,
                  output ready);
endinterface

// ===== src/ssr_cfg_if.sv =====
interface ssr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ssr_pkg::CFG_IDX_W-1:0] index;
  logic [ssr_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/ssr_cfg_regs.sv =====
module ssr_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  ssr_cfg_if.sink           cfg_chan,
  output ssr_pkg::ssr_cfg_t cfg
);

  logic [ssr_pkg::WORD_W-1:0] pattern_r;
  logic [ssr_pkg::LEN_W-1:0]  plen_r;
  logic [ssr_pkg::WORD_W-1:0] repl_r;
  logic [ssr_pkg::LEN_W-1:0]  rlen_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= '0;
      repl_r    <= '0;
      rlen_r    <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        ssr_pkg::REG_PATTERN_BYTES:      pattern_r <= cfg_chan.data;
        ssr_pkg::REG_PATTERN_LENGTH:     plen_r    <= cfg_chan.data[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_REPLACEMENT_BYTES:  repl_r    <= cfg_chan.data;
        ssr_pkg::REG_REPLACEMENT_LENGTH: rlen_r    <= cfg_chan.data[ssr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern = pattern_r;
  assign cfg.repl    = repl_r;
  assign cfg.plen    = ssr_pkg::eff_len(pattern_r, plen_r, ssr_pkg::MAX_PATTERN);
  assign cfg.rlen    = ssr_pkg::eff_len(repl_r, rlen_r, ssr_pkg::MAX_REPLACEMENT);

endmodule

// ===== src/ssr_planner.sv =====
`include "assert_macros.svh"

module ssr_planner (
  input  logic              clk,
  input  logic              rst_n,
  input  ssr_pkg::ssr_cfg_t cfg,
  ssr_in_if.sink            in_chan,
  output ssr_pkg::plan_t    plan,
  output logic              plan_valid,
  input  logic              plan_ready
);

  localparam int NP = ssr_pkg::MAX_PATTERN;

  logic                        in_v_r;
  logic [ssr_pkg::CHAR_W-1:0]  char_r;
  logic                        last_r;
  logic [ssr_pkg::CNT_W-1:0]   cnt_r;

  logic [ssr_pkg::CHAR_W-1:0]  pb [NP];
  logic [NP-1:0]               bmat [NP];
  logic [NP-1:0]               cand;
  logic [ssr_pkg::CNT_W-1:0]   m0;
  logic [ssr_pkg::CNT_W-1:0]   kp;
  logic                        found;
  logic [ssr_pkg::LEN_W-1:0]   n;
  logic [ssr_pkg::CNT_W-1:0]   d;
  logic [ssr_pkg::CNT_W-1:0]   m_after;
  logic [ssr_pkg::POS_W-1:0]   x;
  logic [ssr_pkg::POS_W-1:0]   f;
  logic [ssr_pkg::POS_W-1:0]   total;
  ssr_pkg::mid_kind_t          kind;
  logic                        consume;
  logic                        accept;

  // Border table: bmat[m][k] when pattern prefix k is a proper border of prefix m
  always_comb begin
    for (int i = 0; i < NP; i++) pb[i] = cfg.pattern[ssr_pkg::CHAR_W*i +: ssr_pkg::CHAR_W];
    for (int m = 0; m < NP; m++) begin
      for (int k = 0; k < NP; k++) begin
        bmat[m][k] = (k < m);
        for (int i = 0; i < NP; i++) begin
          if ((i < k) && (k < m) && (pb[i] != pb[ssr_pkg::CNT_W'(m-k+i)])) bmat[m][k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    m0 = (ssr_pkg::LEN_W'(cnt_r) >= cfg.plen) ? '0 : cnt_r;
    // Fallback candidates: the held prefix itself and each of its borders
    for (int k = 0; k < NP; k++) begin
      cand[k] = ((ssr_pkg::CNT_W'(k) == m0) ||
                 ((ssr_pkg::CNT_W'(k) < m0) && bmat[m0][k])) && (pb[k] == char_r);
    end
    found = 1'b0;
    kp    = '0;
    for (int k = 0; k < NP; k++) begin
      if (cand[k]) begin
        found = 1'b1;
        kp    = ssr_pkg::CNT_W'(k);
      end
    end
    n = ssr_pkg::LEN_W'(kp) + ssr_pkg::LEN_W'(1);

    if (cfg.plen == '0) begin
      d       = '0;
      kind    = ssr_pkg::SEG_CHAR;
      m_after = '0;
    end else if (found) begin
      d = m0 - kp;
      if (n >= cfg.plen) begin
        kind    = ssr_pkg::SEG_REPL;
        m_after = '0;
      end else begin
        kind    = ssr_pkg::SEG_NONE;
        m_after = n[ssr_pkg::CNT_W-1:0];
      end
    end else begin
      d       = m0;
      kind    = ssr_pkg::SEG_CHAR;
      m_after = '0;
    end

    unique case (kind)
      ssr_pkg::SEG_REPL: x = cfg.rlen;
      ssr_pkg::SEG_CHAR: x = ssr_pkg::POS_W'(1);
      default:           x = '0;
    endcase
    f = last_r ? ssr_pkg::POS_W'(m_after) : '0;

    plan.b1    = ssr_pkg::POS_W'(d);
    plan.b2    = plan.b1 + x;
    total      = plan.b2 + f;
    plan.kind  = kind;
    plan.ch    = char_r;
    plan.last  = last_r;
    // An end with nothing to say still sends one empty marker
    plan.empty = last_r && (total == '0);
    plan.total = plan.empty ? ssr_pkg::POS_W'(1) : total;
  end

  assign plan_valid    = in_v_r && (plan.total != '0);
  assign consume       = in_v_r && (plan_ready || (plan.total == '0));
  assign in_chan.ready = !in_v_r || consume;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (accept) begin
        in_v_r <= 1'b1;
      end else if (consume) begin
        in_v_r <= 1'b0;
      end
      if (consume) begin
        cnt_r <= last_r ? '0 : m_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_chan.in_char;
      last_r <= in_chan.in_end;
    end
  end

  `SSR_ASSERT(a_flush_clears_count, clk, rst_n, consume && last_r |=> cnt_r == '0)
  `SSR_ASSERT(a_count_below_len, clk, rst_n, consume && cfg.plen != '0 |=> cnt_r < $past(cfg.plen))

endmodule

// ===== src/ssr_emitter.sv =====
`include "assert_macros.svh"

module ssr_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  ssr_pkg::ssr_cfg_t cfg,
  input  ssr_pkg::plan_t    plan,
  input  logic              plan_valid,
  output logic              plan_ready,
  ssr_out_if.source         out_chan
);

  logic                        plan_v_r;
  ssr_pkg::plan_t              plan_r;
  logic [ssr_pkg::POS_W-1:0]   pos_r;
  logic                        out_v_r;
  logic [ssr_pkg::CHAR_W-1:0]  och_r;
  logic                        ovalid_r;
  logic                        oend_r;

  logic [ssr_pkg::POS_W-1:0]   q;
  logic [ssr_pkg::POS_W-1:0]   r;
  logic [ssr_pkg::CHAR_W-1:0]  cur;
  logic                        adv;
  logic                        at_last;

  always_comb begin
    q = pos_r - plan_r.b1;
    r = pos_r - plan_r.b2;
    priority if (plan_r.empty) begin
      cur = '0;
    end else if (pos_r < plan_r.b1) begin
      cur = ssr_pkg::byte_of(cfg.pattern, pos_r[ssr_pkg::CNT_W-1:0]);
    end else if (pos_r < plan_r.b2) begin
      unique case (plan_r.kind)
        ssr_pkg::SEG_REPL: cur = ssr_pkg::byte_of(cfg.repl, q[ssr_pkg::CNT_W-1:0]);
        default:           cur = plan_r.ch;
      endcase
    end else begin
      cur = ssr_pkg::byte_of(cfg.pattern, r[ssr_pkg::CNT_W-1:0]);
    end
  end

  assign adv        = plan_v_r && (!out_v_r || out_chan.ready);
  assign at_last    = (pos_r == plan_r.total - ssr_pkg::POS_W'(1));
  assign plan_ready = !plan_v_r || (adv && at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (plan_valid && plan_ready) begin
        plan_v_r <= 1'b1;
      end else if (adv && at_last) begin
        plan_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (plan_valid && plan_ready) begin
      plan_r <= plan;
      pos_r  <= '0;
    end else if (adv) begin
      pos_r <= pos_r + ssr_pkg::POS_W'(1);
    end
    if (adv) begin
      och_r    <= cur;
      ovalid_r <= !plan_r.empty;
      oend_r   <= plan_r.last && at_last;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.out_char  = och_r;
  assign out_chan.out_valid = ovalid_r;
  assign out_chan.out_end   = oend_r;

  `SSR_ASSERT(a_pos_in_range, clk, rst_n, plan_v_r |-> pos_r < plan_r.total)
  `SSR_ASSERT(a_marker_alone, clk, rst_n, plan_v_r && plan_r.empty |-> plan_r.total == 1 && pos_r == '0)
  `SSR_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_v_r && !plan_v_r)

endmodule

// ===== src/stream_substring_replace.sv =====
// Streaming find-and-replace over a byte string.
// in_chan carries one source byte per transaction (in_char, with in_end on the final
// byte); out_chan carries the rewritten string, one result per transaction (out_char,
// out_valid, out_end). cfg_chan writes the pattern, its length, the replacement and
// its length by register index; write only while the block is idle.
// Every leftmost, non-overlapping pattern occurrence is replaced. On a mismatch the
// block falls back to the longest usable border of the held prefix and releases the
// bytes that can no longer match; at end of string the held prefix is flushed.
// The first result of an item passes the input, plan and output registers.
// Throughput: one result per cycle while the receiver is ready, set by the single
// output register; an item yielding one result is taken every cycle, one yielding
// more holds the input side until its last is sent (up to 15 results per item).
// A string ending with no bytes to send yields one empty end marker (out_valid 0).
// Reset clears the configuration to zero (pass-through) and the match count.
// When the receiver stalls, the output register holds its transaction and the
// input register fills, after which in_chan.ready drops.
module stream_substring_replace (
  input  logic       clk,
  input  logic       rst_n,
  ssr_cfg_if.sink    cfg_chan,
  ssr_in_if.sink     in_chan,
  ssr_out_if.source  out_chan
);

  ssr_pkg::ssr_cfg_t cfg;
  ssr_pkg::plan_t    plan;
  logic              plan_valid;
  logic              plan_ready;

  // Configuration registers and effective lengths
  ssr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // Input register, match count and per-item result plan
  ssr_planner u_plan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_chan    (in_chan),
    .plan       (plan),
    .plan_valid (plan_valid),
    .plan_ready (plan_ready)
  );

  // Walk the plan one result per cycle, while the receiver is ready, into the output register
  ssr_emitter u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .plan       (plan),
    .plan_valid (plan_valid),
    .plan_ready (plan_ready),
    .out_chan   (out_chan)
  );

endmodule
